[hw/rtl/cpc_pkg.sv]
// Package for the contrast pixel counter: shared widths, register indexes,
// configuration, position and line buffer entry structs. Depends on nothing else.
package cpc_pkg;

  localparam int PIXEL_W    = 8;
  localparam int COUNT_W    = 20;
  localparam int THRESH_W   = 8;
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [THRESH_W-1:0]   THRESH_RESET = 8'd128;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET   = 11'd200;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET   = 10'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ROW_COUNT = 2'd1,
    REG_COL_COUNT = 2'd2
  } cfg_reg_t;

  // Register values as written, before any clamping.
  typedef struct packed {
    logic [THRESH_W-1:0]   threshold;
    logic [ROWS_CFG_W-1:0] rows;
    logic [COLS_CFG_W-1:0] cols;
  } cfg_t;

  // Where the current pixel sits in the frame.
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  // One line buffer entry: the pixel and its contrast mark.
  typedef struct packed {
    logic [PIXEL_W-1:0] pix;
    logic               flag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hw/rtl/cpc_if.sv]
// Channel interfaces of the contrast pixel counter: pixel input, result
// output and configuration write. Depends on cpc_pkg.
interface cpc_pix_if;
  logic                         valid;
  logic                         ready;
  logic [cpc_pkg::PIXEL_W-1:0]  pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface cpc_res_if;
  logic                         valid;
  logic                         ready;
  logic [cpc_pkg::COUNT_W-1:0]  contrast_count;
  logic                         frame_done;
  modport source (output valid, output contrast_count, output frame_done, input ready);
  modport sink (input valid, input contrast_count, input frame_done, output ready);
endinterface

interface cpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpc_pkg::CFG_IDX_W-1:0]  index;
  logic [cpc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cpc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
module cpc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/cpc_cfg.sv]
// Configuration registers of the contrast pixel counter.
// Depends on cpc_pkg and the cpc_cfg_if interface.
module cpc_cfg (
  input  logic          clk,
  input  logic          rst,
  cpc_cfg_if.sink       cfg,
  output cpc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold <= cpc_pkg::THRESH_RESET;
      regs.rows      <= cpc_pkg::ROWS_RESET;
      regs.cols      <= cpc_pkg::COLS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        cpc_pkg::REG_THRESHOLD: regs.threshold <= cfg.data[cpc_pkg::THRESH_W-1:0];
        cpc_pkg::REG_ROW_COUNT: regs.rows      <= cfg.data[cpc_pkg::ROWS_CFG_W-1:0];
        cpc_pkg::REG_COL_COUNT: regs.cols      <= cfg.data[cpc_pkg::COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/cpc_pos.sv]
// Raster position tracker: column and row of the next pixel, and its place
// relative to the frame edges. Depends on cpc_pkg.
module cpc_pos #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  cpc_pkg::cfg_t                  regs,
  output logic [$clog2(MAX_COLUMNS)-1:0] col,
  output cpc_pkg::pos_flags_t            flags
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [ROW_W-1:0] row;
  logic [31:0]      cols_raw;
  logic [31:0]      rows_raw;
  logic [COL_W:0]   cols_eff;
  logic [ROW_W:0]   rows_eff;

  // A size of zero means one; a size beyond the maximum saturates.
  always_comb begin
    cols_raw = 32'(regs.cols);
    rows_raw = 32'(regs.rows);
    if (cols_raw == 32'd0) begin
      cols_eff = (COL_W+1)'(1);
    end else if (cols_raw > 32'(MAX_COLUMNS)) begin
      cols_eff = (COL_W+1)'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_raw[COL_W:0];
    end
    if (rows_raw == 32'd0) begin
      rows_eff = (ROW_W+1)'(1);
    end else if (rows_raw > 32'(MAX_ROWS)) begin
      rows_eff = (ROW_W+1)'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw[ROW_W:0];
    end
    flags.first_col = (col == '0);
    flags.first_row = (row == '0);
    flags.last_col  = ({1'b0, col} + (COL_W+1)'(1)) >= cols_eff;
    flags.last_row  = ({1'b0, row} + (ROW_W+1)'(1)) >= rows_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (flags.last_col) begin
        col <= '0;
        row <= flags.last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

[hw/rtl/cpc_eval.sv]
// Per-pixel evaluation: contrast tests against the left and upper
// neighbours, line buffer write-back with forwarding, and the running
// count. Depends on cpc_pkg.
module cpc_eval #(
  parameter int COL_W = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [cpc_pkg::PIXEL_W-1:0]  pixel,
  input  logic [COL_W-1:0]             col,
  input  cpc_pkg::pos_flags_t          flags,
  input  logic [cpc_pkg::THRESH_W-1:0] threshold,
  input  cpc_pkg::entry_t              rd_entry,
  output logic                         wr_en,
  output logic [COL_W-1:0]             wr_addr,
  output cpc_pkg::entry_t              wr_entry,
  output logic [cpc_pkg::COUNT_W-1:0]  count,
  output logic                         done
);

  function automatic logic differs(input logic [cpc_pkg::PIXEL_W-1:0] a,
                                   input logic [cpc_pkg::PIXEL_W-1:0] b,
                                   input logic [cpc_pkg::THRESH_W-1:0] th);
    logic [cpc_pkg::PIXEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > th;
  endfunction

  logic [cpc_pkg::PIXEL_W-1:0] left_pixel;
  logic                        left_flag;
  logic [COL_W-1:0]            left_col;
  logic                        lw_valid;
  logic [COL_W-1:0]            lw_addr;
  cpc_pkg::entry_t             lw_data;
  logic [cpc_pkg::COUNT_W-1:0] running_count;

  cpc_pkg::entry_t             above;
  logic                        left_hit;
  logic                        up_hit;
  logic                        own;
  logic                        left_flag_next;
  logic                        above_flag;
  logic [1:0]                  incr;
  logic [cpc_pkg::COUNT_W:0]   sum;

  always_comb begin
    // The previous pixel's entry is still held here and not yet in the RAM;
    // the entry written one beat earlier may have missed the RAM read.
    if (col == left_col) begin
      above = '{pix: left_pixel, flag: left_flag};
    end else if (lw_valid && (col == lw_addr)) begin
      above = lw_data;
    end else begin
      above = rd_entry;
    end

    left_hit       = !flags.first_col && differs(pixel, left_pixel, threshold);
    up_hit         = !flags.first_row && differs(pixel, above.pix, threshold);
    own            = left_hit | up_hit;
    left_flag_next = left_flag | left_hit;
    above_flag     = above.flag | up_hit;
    done           = flags.last_col & flags.last_row;

    incr = {1'b0, !flags.first_row & above_flag}
         + {1'b0, flags.last_row & !flags.first_col & left_flag_next}
         + {1'b0, done & own};
    sum  = {1'b0, running_count} + (cpc_pkg::COUNT_W+1)'(incr);
    count = (sum > {1'b0, cpc_pkg::COUNT_MAX}) ? cpc_pkg::COUNT_MAX
                                               : sum[cpc_pkg::COUNT_W-1:0];

    wr_en    = fire;
    wr_addr  = left_col;
    wr_entry = '{pix: left_pixel, flag: left_flag_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel    <= '0;
      left_flag     <= 1'b0;
      left_col      <= '0;
      lw_valid      <= 1'b0;
      running_count <= '0;
    end else if (fire) begin
      left_pixel    <= pixel;
      left_flag     <= own;
      left_col      <= col;
      lw_valid      <= 1'b1;
      running_count <= done ? '0 : count;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lw_addr <= wr_addr;
      lw_data <= wr_entry;
    end
  end

endmodule

[hw/rtl/contrast_pixel_counter.sv]
// Top level of the contrast pixel counter: pixel and result channels,
// configuration port. Depends on cpc_pkg, the cpc interfaces, cpc_cfg,
// cpc_pos, cpc_eval and cpc_ram.

// Counts the contrasting pixels of a grey frame that arrives in raster
// order, one 8-bit pixel per beat on the pix channel. A pixel contrasts when
// the absolute difference to any of its up, down, left or right neighbours
// is greater than the threshold register. Every pixel beat gives exactly one
// result beat: the number of contrasting pixels that are final so far in the
// frame, and frame_done on the frame's last pixel, after which position and
// count start again at zero. The block takes one pixel per clock cycle in
// steady state while result beats are taken; each pixel does one read and
// one write of the line buffer RAM. The result of a pixel is loaded into the
// output register from the pixel stage register when that stage moves on.
// An output register decouples the two sides, so a new pixel is taken while
// a result still waits. Registers: index 0 threshold
// (reset 128), index 1 rows per frame (reset 200), index 2 pixels per row
// (reset 320). A size of zero counts as one and a size above the maximum
// saturates. Write the registers only while no pixel is in flight; a row
// length may only grow at a frame boundary. The count saturates at its
// maximum value. The line buffer needs no clearing after reset.
module contrast_pixel_counter #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 1024
) (
  input  logic     clk,
  input  logic     rst,
  cpc_pix_if.sink  pix,
  cpc_res_if.source res,
  cpc_cfg_if.sink  cfg
);

  localparam int COL_W = $clog2(MAX_COLUMNS);

  cpc_pkg::cfg_t              regs;
  cpc_pkg::pos_flags_t        pos_flags;
  logic [COL_W-1:0]           pos_col;
  logic                       accept;
  logic                       advance;

  // Pixel stage: holds the accepted pixel while its line buffer read is in
  // flight.
  logic                        a_valid;
  logic [cpc_pkg::PIXEL_W-1:0] a_pixel;
  logic [COL_W-1:0]            a_col;
  cpc_pkg::pos_flags_t         a_flags;

  logic [cpc_pkg::ENTRY_W-1:0] ram_rd_data;
  logic                        wr_en;
  logic [COL_W-1:0]            wr_addr;
  cpc_pkg::entry_t             wr_entry;
  logic [cpc_pkg::COUNT_W-1:0] count;
  logic                        done;

  // The pixel stage moves on when the output register is free or drains
  // in the same cycle.
  assign advance   = a_valid && (!res.valid || res.ready);
  assign pix.ready = !a_valid || advance;
  assign accept    = pix.valid && pix.ready;

  cpc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cpc_pos #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_pos (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .regs    (regs),
    .col     (pos_col),
    .flags   (pos_flags)
  );

  // Line buffer: one entry per column with the pixel of the row above and
  // its contrast mark that still waits for the pixel below.
  cpc_ram #(
    .WIDTH (cpc_pkg::ENTRY_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (pos_col),
    .rd_data (ram_rd_data)
  );

  cpc_eval #(
    .COL_W (COL_W)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .pixel     (a_pixel),
    .col       (a_col),
    .flags     (a_flags),
    .threshold (regs.threshold),
    .rd_entry  (cpc_pkg::entry_t'(ram_rd_data)),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .count     (count),
    .done      (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pixel <= pix.pixel_value;
      a_col   <= pos_col;
      a_flags <= pos_flags;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.contrast_count <= count;
      res.frame_done     <= done;
    end
  end

endmodule
